/* rtl/swpec_pkg.sv */
`default_nettype none

package swpec_pkg;

   localparam int STORE_DEPTH_DEFAULT = 64;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int EVENT_TIME_W = 32;
   localparam int COUNT_W = 7;
   localparam int WINDOW_W = 16;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRUNE,
      ST_DONE
   } swpec_state_type;

   // per-cell control: shift toward the head, or load the new timestamp
   typedef struct packed {
      logic shift;
      logic write;
   } swpec_cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/swpec_cell.sv */
`default_nettype none

module swpec_cell #(
   parameter int TIME_BITS = swpec_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire swpec_pkg::swpec_cell_ctrl_type ctrl,
   input  wire logic [TIME_BITS-1:0]          write_time,
   input  wire logic [TIME_BITS-1:0]          neighbor_time,
   output logic      [TIME_BITS-1:0]          cell_time
);
   import swpec_pkg::*;

   logic [TIME_BITS-1:0] time_ff;
   logic [TIME_BITS-1:0] time_in;

   // a write wins over the shift: the new entry lands behind the shifted ones
   always_comb begin
      if (ctrl.write) begin
         time_in = write_time;
      end else if (ctrl.shift) begin
         time_in = neighbor_time;
      end else begin
         time_in = time_ff;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
   end

   assign cell_time = time_ff;

endmodule

`default_nettype wire

/* rtl/sliding_window_peak_event_count_core.sv */
`default_nettype none

// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_event_time
// rsp       out        rsp_valid/rsp_ready  rsp_current_count, rsp_best_count,
//                                           rsp_best_start, rsp_best_end, rsp_overflow
// csr       in         csr_write_enable     csr_write_data (window_seconds)
//
// one request is worked on at a time; after an accept the core pops old entries
// from the window one by one in the prune state before it takes the next request
// the pops run through the chain of cells: the head sits in cell 0 and each pop
// shifts the whole chain one place per cycle
// reset is synchronous; it clears the count and the peak and reloads the window register
// a stalled response holds in its output register; the core takes the next
// request while it waits, and stalls in the done state only if a second result
// is ready before the first is taken

module sliding_window_peak_event_count_core #(
   parameter int STORE_DEPTH = swpec_pkg::STORE_DEPTH_DEFAULT,
   parameter int TIME_BITS   = swpec_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [swpec_pkg::EVENT_TIME_W-1:0] req_event_time,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [swpec_pkg::COUNT_W-1:0]     rsp_current_count,
   output logic      [swpec_pkg::COUNT_W-1:0]     rsp_best_count,
   output logic      [swpec_pkg::EVENT_TIME_W-1:0] rsp_best_start,
   output logic      [swpec_pkg::EVENT_TIME_W-1:0] rsp_best_end,
   output logic                                   rsp_overflow,
   // configuration
   input  wire logic                              csr_write_enable,
   input  wire logic [swpec_pkg::WINDOW_W-1:0]    csr_write_data
);
   import swpec_pkg::*;

   // count must hold the depth itself
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   // fsm
   swpec_state_type state_ff, state_in;

   // window bookkeeping
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 ovf_ff, ovf_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;

   // peak record
   logic [CNT_W-1:0]     peak_count_ff, peak_count_in;
   logic [TIME_BITS-1:0] peak_first_ff, peak_first_in;
   logic [TIME_BITS-1:0] peak_last_ff, peak_last_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0]      rsp_best_ff, rsp_best_in;
   logic [EVENT_TIME_W-1:0] rsp_start_ff, rsp_start_in;
   logic [EVENT_TIME_W-1:0] rsp_end_ff, rsp_end_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // cell chain
   logic [TIME_BITS-1:0] cell_time [STORE_DEPTH];
   swpec_cell_ctrl_type  cell_ctrl [STORE_DEPTH];
   logic [TIME_BITS-1:0] head_time;
   logic [TIME_BITS-1:0] new_time;
   logic [CNT_W-1:0]     write_slot;

   logic accept;
   logic full;
   logic pop_ok;
   logic out_free;
   logic load_rsp;
   logic shift;
   logic peak_win;

   assign head_time = cell_time[0];
   assign new_time  = TIME_BITS'(req_event_time);
   assign full      = (occ_ff == CNT_W'(STORE_DEPTH));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // oldest entry leaves when the span exceeds the window; time going
   // backwards counts as no span
   assign pop_ok = (occ_ff != '0) && (now_ff >= head_time)
                   && ((now_ff - head_time) > TIME_BITS'(window_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            if (!pop_ok) begin
               state_in = out_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      accept    = 1'b0;
      load_rsp  = 1'b0;
      shift     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            // a full store drops its oldest entry as the new one goes in
            shift     = req_valid && full;
         end
         ST_PRUNE: begin
            shift    = pop_ok;
            load_rsp = !pop_ok && out_free;
         end
         ST_DONE: begin
            load_rsp = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // new entry goes behind the last one, or into the last cell after a drop
   assign write_slot = full ? CNT_W'(STORE_DEPTH - 1) : occ_ff;

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      logic [TIME_BITS-1:0] neighbor;

      if (i == STORE_DEPTH - 1) begin : g_last
         assign neighbor = cell_time[i];
      end else begin : g_mid
         assign neighbor = cell_time[i+1];
      end

      assign cell_ctrl[i].shift = shift;
      assign cell_ctrl[i].write = accept && (write_slot == CNT_W'(i));

      swpec_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[i]),
         .write_time   (new_time),
         .neighbor_time(neighbor),
         .cell_time    (cell_time[i])
      );
   end

   // count, request latch and window register
   always_comb begin
      occ_in    = occ_ff;
      now_in    = now_ff;
      ovf_in    = ovf_ff;
      window_in = csr_write_enable ? csr_write_data : window_ff;
      if (accept) begin
         now_in = new_time;
         ovf_in = full;
         if (!full) begin
            occ_in = occ_ff + CNT_W'(1);
         end
      end else if (shift) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   // peak only moves on a strictly larger window
   assign peak_win = occ_ff > peak_count_ff;

   always_comb begin
      peak_count_in = peak_count_ff;
      peak_first_in = peak_first_ff;
      peak_last_in  = peak_last_ff;
      if (load_rsp && peak_win) begin
         peak_count_in = occ_ff;
         peak_first_in = head_time;
         peak_last_in  = now_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = COUNT_W'(occ_ff);
         rsp_best_in  = COUNT_W'(peak_count_in);
         rsp_start_in = EVENT_TIME_W'(peak_first_in);
         rsp_end_in   = EVENT_TIME_W'(peak_last_in);
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         window_ff     <= WINDOW_RESET;
         peak_count_ff <= '0;
         peak_first_ff <= '0;
         peak_last_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         window_ff     <= window_in;
         peak_count_ff <= peak_count_in;
         peak_first_ff <= peak_first_in;
         peak_last_ff  <= peak_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      ovf_ff       <= ovf_in;
      rsp_count_ff <= rsp_count_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_count = rsp_count_ff;
   assign rsp_best_count    = rsp_best_ff;
   assign rsp_best_start    = rsp_start_ff;
   assign rsp_best_end      = rsp_end_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

/* rtl/swpec_checker.sv */
`default_nettype none

module swpec_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [swpec_pkg::COUNT_W-1:0] rsp_current_count,
   input wire logic [swpec_pkg::COUNT_W-1:0] rsp_best_count
);
   import swpec_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_count))
      else $error("response dropped or changed while stalled");

   // one request at a time: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is at work");

   // the newest event is always inside its own window
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_current_count != '0)
      else $error("response with an empty window");

   // the peak is never below the current window
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_best_count >= rsp_current_count)
      else $error("peak below current count");

endmodule

bind sliding_window_peak_event_count_core swpec_checker u_swpec_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swpec_pkg::*;

   // ring of timestamps inside the sliding window, same depth as the core
   localparam int RING_DEPTH      = STORE_DEPTH_DEFAULT;
   localparam int RESET_CYCLES    = 4;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 193;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 80;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int REPORT_LIMIT    = 10;
   // long receiver hold, placed in the middle of a random phase
   localparam int PRESSURE_AT     = 700;
   localparam int PRESSURE_HOLD   = 300;

   // one response as the core reports it
   typedef struct packed {
      logic [COUNT_W-1:0]      current_count;
      logic [COUNT_W-1:0]      best_count;
      logic [EVENT_TIME_W-1:0] best_start;
      logic [EVENT_TIME_W-1:0] best_end;
      logic                    overflow;
   } peak_report_type;

   // directed row: timestamp, plus a hand-written response where it is obvious
   typedef struct packed {
      logic [EVENT_TIME_W-1:0] stamp;
      logic                    typed;
      peak_report_type         want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 18;

   // window is still at its reset value of 10 for all of these
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      // first event after reset
      '{32'h0000_0000, 1'b1, {7'd1, 7'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}},
      // span exactly equal to the window stays in
      '{32'h0000_000A, 1'b1, {7'd2, 7'd2, 32'h0000_0000, 32'h0000_000A, 1'b0}},
      // one past the window pops the head, peak tie leaves best alone
      '{32'h0000_000B, 1'b1, {7'd2, 7'd2, 32'h0000_0000, 32'h0000_000A, 1'b0}},
      // time going backwards: nothing popped
      '{32'h0000_0005, 1'b1, {7'd3, 7'd3, 32'h0000_000A, 32'h0000_0005, 1'b0}},
      // all-ones time flushes every older entry
      '{32'hFFFF_FFFF, 1'b1, {7'd1, 7'd3, 32'h0000_000A, 32'h0000_0005, 1'b0}},
      '{32'hFFFF_FFFF, 1'b1, {7'd2, 7'd3, 32'h0000_000A, 32'h0000_0005, 1'b0}},
      // back to zero: backwards again, ties the peak
      '{32'h0000_0000, 1'b1, {7'd3, 7'd3, 32'h0000_000A, 32'h0000_0005, 1'b0}},
      '{32'h0000_0000, 1'b1, {7'd4, 7'd4, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'h5555_555F, 1'b0, '0},
      '{32'h5555_5560, 1'b0, '0},
      '{32'h0000_0001, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'hFFFF_FFFE, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [EVENT_TIME_W-1:0] req_event_time = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [COUNT_W-1:0]      rsp_current_count;
   logic [COUNT_W-1:0]      rsp_best_count;
   logic [EVENT_TIME_W-1:0] rsp_best_start;
   logic [EVENT_TIME_W-1:0] rsp_best_end;
   logic                    rsp_overflow;
   logic                    csr_write_enable = 1'b0;
   logic [WINDOW_W-1:0]     csr_write_data = '0;

   // predictor state: window ring, pointers, fill level and recorded peak
   logic [EVENT_TIME_W-1:0] event_ring [RING_DEPTH];
   int unsigned             ring_head = 0;
   int unsigned             ring_tail = 0;
   int unsigned             ring_fill = 0;
   int unsigned             peak_fill = 0;
   logic [EVENT_TIME_W-1:0] peak_first = '0;
   logic [EVENT_TIME_W-1:0] peak_last = '0;
   logic [WINDOW_W-1:0]     window_setting = WINDOW_RESET;

   peak_report_type         pending_reports [$];
   int unsigned             requests_taken = 0;
   int unsigned             mismatch_count = 0;
   int unsigned             cycle_count = 0;
   logic [EVENT_TIME_W-1:0] stamp_cursor = '0;

   sliding_window_peak_event_count_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_event_time    (req_event_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_current_count (rsp_current_count),
      .rsp_best_count    (rsp_best_count),
      .rsp_best_start    (rsp_best_start),
      .rsp_best_end      (rsp_best_end),
      .rsp_overflow      (rsp_overflow),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // push one timestamp into the window ring, drop old entries, update the peak
   function automatic peak_report_type tally_event(input logic [EVENT_TIME_W-1:0] stamp);
      peak_report_type rpt;
      rpt.overflow = 1'b0;
      // ring full: oldest entry goes before the push
      if (ring_fill >= RING_DEPTH) begin
         ring_head = (ring_head + 1) % RING_DEPTH;
         ring_fill--;
         rpt.overflow = 1'b1;
      end
      event_ring[ring_tail] = stamp;
      ring_tail = (ring_tail + 1) % RING_DEPTH;
      ring_fill++;
      // a head newer than the new event never gets popped
      while (ring_fill > 0 && stamp >= event_ring[ring_head] &&
             (stamp - event_ring[ring_head]) > window_setting) begin
         ring_head = (ring_head + 1) % RING_DEPTH;
         ring_fill--;
      end
      // only a strictly larger window replaces the peak
      if (ring_fill > peak_fill) begin
         peak_fill  = ring_fill;
         peak_first = event_ring[ring_head];
         peak_last  = stamp;
      end
      rpt.current_count = ring_fill[COUNT_W-1:0];
      rpt.best_count    = peak_fill[COUNT_W-1:0];
      rpt.best_start    = peak_first;
      rpt.best_end      = peak_last;
      return rpt;
   endfunction

   // idle cycles before a request: mostly none or short, now and then long
   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // next timestamp: mostly non-decreasing, some backward steps and jumps
   function automatic logic [EVENT_TIME_W-1:0] next_stamp(
      input logic [EVENT_TIME_W-1:0] last,
      input int unsigned             win,
      input int unsigned             step_cap,
      input bit                      flood
   );
      int unsigned roll;
      // flood phases pack events close together so the ring fills up
      if (flood && $urandom_range(0, 9) != 0) begin
         return last + $urandom_range(0, step_cap);
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         return last;
      end else if (roll < 60) begin
         return last + $urandom_range(0, step_cap);
      end else if (roll < 75) begin
         // right around the window edge
         return last + win + $urandom_range(0, 2) - 1;
      end else if (roll < 85) begin
         return last + $urandom_range(0, 3 * win + 3);
      end else if (roll < 90) begin
         return $urandom();
      end else if (roll < 95) begin
         return last - $urandom_range(0, win + 2);
      end
      return 32'hFFFF_FFFF - $urandom_range(0, 3 * win + 3);
   endfunction

   // offer one request and hold it until accepted, then log what it should give
   task automatic offer_event(
      input logic [EVENT_TIME_W-1:0] stamp,
      input logic                    typed,
      input peak_report_type         want,
      input bit                      calm
   );
      int unsigned     gap;
      peak_report_type predicted;
      gap = pick_gap(calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_event_time <= stamp;
      do @(posedge clock); while (!req_ready);
      requests_taken++;
      // predictor runs on every request so typed rows keep its state in step
      predicted = tally_event(stamp);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   // change the window only once every response is back
   task automatic load_window(input logic [WINDOW_W-1:0] win);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= win;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_setting = win;
   endtask

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   task automatic compare_field(
      input string       field_name,
      input logic [31:0] want,
      input logic [31:0] got
   );
      if (got !== want) begin
         flag_error($sformatf("%s mismatch: expected 0x%08h, got 0x%08h",
                              field_name, want, got));
      end
   endtask

   // response check against the oldest pending expectation
   always @(posedge clock) begin
      peak_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            flag_error("response with no request pending");
         end else begin
            want = pending_reports.pop_front();
            compare_field("current_count", 32'(want.current_count), 32'(rsp_current_count));
            compare_field("best_count", 32'(want.best_count), 32'(rsp_best_count));
            compare_field("best_start", want.best_start, rsp_best_start);
            compare_field("best_end", want.best_end, rsp_best_end);
            compare_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
         end
      end
   end

   // response side: random stalls in busy stretches, plus one long hold
   initial begin : response_drain
      int unsigned stall_left;
      int unsigned mode_left;
      int unsigned roll;
      bit          calm;
      bit          pressure_done;
      stall_left    = 0;
      mode_left     = 150;
      calm          = 1'b0;
      pressure_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         // hold off long enough for the core to back up into the request side
         if (!pressure_done && requests_taken >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            stall_left    = PRESSURE_HOLD;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp_ready <= 1'b1;
            end else if (roll < 95) begin
               rsp_ready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               rsp_ready <= 1'b0;
               stall_left = $urandom_range(10, 60);
            end
         end
      end
   end

   // hang guard
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int unsigned win;
      int unsigned step_cap;
      bit          flood;
      bit          calm;
      calm = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset window
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_event(DIRECTED_TABLE[i].stamp, DIRECTED_TABLE[i].typed,
                     DIRECTED_TABLE[i].want, 1'b0);
      end
      stamp_cursor = DIRECTED_TABLE[DIRECTED_ROWS-1].stamp;

      // random phases, each with its own window and event density
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0, 7: begin
               win = 0;
            end
            1, 5: begin
               win = 32'h0000_FFFF;
            end
            2: begin
               win = 1;
            end
            default: begin
               win = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 64)
                                                 : $urandom_range(0, 65535);
            end
         endcase
         flood    = (p == 5) || (p == 7) || ($urandom_range(0, 3) == 0);
         step_cap = flood ? (win >> $urandom_range(8, 16)) : (win >> $urandom_range(0, 6));
         load_window(WINDOW_W'(win));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // stretches with no sender idling
            if (n % 100 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
            stamp_cursor = next_stamp(stamp_cursor, win, step_cap, flood);
            offer_event(stamp_cursor, 1'b0, '0, calm);
         end
      end

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // catch any stray response after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
